FILE: rtl/core/dpjq_pkg.sv
`default_nettype none

package dpjq_pkg;

	localparam int QUEUE_DEPTH_DEF = 128;
	localparam int ID_W            = 16;
	localparam int PAGES_W         = 16;
	localparam int ENTRY_W         = ID_W + PAGES_W;

	typedef enum logic [1:0] {
		OP_SUBMIT  = 2'd0,
		OP_PROCESS = 2'd1,
		OP_SEARCH  = 2'd2,
		OP_CANCEL  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_DUPLICATE = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_POP  = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/core/dpjq_ram.sv
`default_nettype none

module dpjq_ram
	import dpjq_pkg::*;
#(
	parameter int WIDTH = ENTRY_W,
	parameter int DEPTH = QUEUE_DEPTH_DEF,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/core/dual_priority_job_queue.sv
// Submit, search and cancel walk the priority queue and then the normal queue with one
// shared id comparator, one entry per cycle; a search or duplicate hit ends the walk
// early. Process pops the head of the priority queue, or of the normal queue when the
// priority queue is empty, and reports ST_EMPTY when both are empty.
// One item in flight; s_tready is high only while the sequencer is idle. Reset (arst_n
// low) clears heads, tails, counts and the output valid; queue memories are not cleared.
`default_nettype none

module dual_priority_job_queue
	import dpjq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	localparam int PW = $clog2(QUEUE_DEPTH),
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // job_id[15:0], page_count[31:16]
	input  wire logic [2:0]  s_tuser,  // operation[1:0], is_priority[2]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,  // out_job_id[15:0], out_pages[31:16]
	output logic      [3:0]  m_tuser   // status[2:0], from_priority[3]
);

	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

	function automatic logic [PW-1:0] wrap_next(input logic [PW-1:0] p);
		return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	state_t               state_q;
	op_t                  op_q;
	logic [ID_W-1:0]      id_q;
	logic [PAGES_W-1:0]   pages_q;
	logic                 prio_q;
	logic                 qsel_q;   // queue being walked: 1 priority
	logic [PW-1:0]        rd_ptr_q, wr_ptr_q;
	logic [CW-1:0]        left_q, kept_q;
	logic                 pend_q, hit_q;

	logic [PW-1:0]        p_head_q, p_tail_q, n_head_q, n_tail_q;
	logic [CW-1:0]        p_cnt_q, n_cnt_q;

	status_t              res_status_q;
	logic                 res_from_q;
	logic [ID_W-1:0]      res_id_q;
	logic [PAGES_W-1:0]   res_pages_q;

	logic                 m_tvalid_q;
	status_t              m_status_q;
	logic                 m_from_q;
	logic [ID_W-1:0]      m_id_q;
	logic [PAGES_W-1:0]   m_pages_q;

	logic [ENTRY_W-1:0]   p_rdata, n_rdata, sel_rdata, wdata;
	logic [PW-1:0]        rd_addr, p_waddr, n_waddr;
	logic                 p_we, n_we;
	logic                 match, walk_end, tgt_full, push_go, keep_wr, in_xfer, out_load;
	op_t                  in_op;

	assign in_op     = op_t'(s_tuser[1:0]);
	assign s_tready  = (state_q == S_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign out_load  = (state_q == S_FIN) && (!m_tvalid_q || m_tready);

	assign sel_rdata = qsel_q ? p_rdata : n_rdata;
	assign match     = (sel_rdata[ENTRY_W-1:PAGES_W] == id_q);
	assign walk_end  = (left_q == '0) && !pend_q;
	assign tgt_full  = prio_q ? (p_cnt_q == FULL_CNT) : (n_cnt_q == FULL_CNT);
	assign push_go   = (state_q == S_SCAN) && (op_q == OP_SUBMIT) && walk_end && !qsel_q
		&& !tgt_full;
	assign keep_wr   = (state_q == S_SCAN) && (op_q == OP_CANCEL) && pend_q && !match;

	assign p_we    = (keep_wr && qsel_q) || (push_go && prio_q);
	assign n_we    = (keep_wr && !qsel_q) || (push_go && !prio_q);
	assign p_waddr = (op_q == OP_CANCEL) ? wr_ptr_q : p_tail_q;
	assign n_waddr = (op_q == OP_CANCEL) ? wr_ptr_q : n_tail_q;
	assign wdata   = (op_q == OP_CANCEL) ? sel_rdata : {id_q, pages_q};

	// idle: present the head that a process would pop
	assign rd_addr = (state_q == S_IDLE) ? ((p_cnt_q != '0) ? p_head_q : n_head_q) : rd_ptr_q;

	dpjq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_prio_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (wdata),
		.raddr (rd_addr),
		.rdata (p_rdata)
	);

	dpjq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_norm_ram (
		.clk   (clk),
		.we    (n_we),
		.waddr (n_waddr),
		.wdata (wdata),
		.raddr (rd_addr),
		.rdata (n_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_SUBMIT;
			id_q         <= '0;
			pages_q      <= '0;
			prio_q       <= 1'b0;
			qsel_q       <= 1'b0;
			rd_ptr_q     <= '0;
			wr_ptr_q     <= '0;
			left_q       <= '0;
			kept_q       <= '0;
			pend_q       <= 1'b0;
			hit_q        <= 1'b0;
			p_head_q     <= '0;
			p_tail_q     <= '0;
			p_cnt_q      <= '0;
			n_head_q     <= '0;
			n_tail_q     <= '0;
			n_cnt_q      <= '0;
			res_status_q <= ST_OK;
			res_from_q   <= 1'b0;
			res_id_q     <= '0;
			res_pages_q  <= '0;
			m_tvalid_q   <= 1'b0;
			m_status_q   <= ST_OK;
			m_from_q     <= 1'b0;
			m_id_q       <= '0;
			m_pages_q    <= '0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						op_q         <= in_op;
						id_q         <= s_tdata[ID_W-1:0];
						pages_q      <= s_tdata[ID_W+PAGES_W-1:ID_W];
						prio_q       <= s_tuser[2];
						res_status_q <= (in_op == OP_PROCESS && p_cnt_q == '0 && n_cnt_q == '0)
							? ST_EMPTY : ST_OK;
						res_from_q   <= 1'b0;
						res_id_q     <= '0;
						res_pages_q  <= '0;
						if (in_op == OP_PROCESS) begin
							if (p_cnt_q != '0) begin
								qsel_q   <= 1'b1;
								p_head_q <= wrap_next(p_head_q);
								p_cnt_q  <= p_cnt_q - 1'b1;
								state_q  <= S_POP;
							end else if (n_cnt_q != '0) begin
								qsel_q   <= 1'b0;
								n_head_q <= wrap_next(n_head_q);
								n_cnt_q  <= n_cnt_q - 1'b1;
								state_q  <= S_POP;
							end else begin
								state_q  <= S_FIN;
							end
						end else begin
							qsel_q   <= 1'b1;
							rd_ptr_q <= p_head_q;
							wr_ptr_q <= p_head_q;
							left_q   <= p_cnt_q;
							kept_q   <= '0;
							hit_q    <= 1'b0;
							pend_q   <= 1'b0;
							state_q  <= S_SCAN;
						end
					end
				end

				S_SCAN: begin
					// issue one read per cycle, compare the entry read last cycle
					if (left_q != '0) begin
						rd_ptr_q <= wrap_next(rd_ptr_q);
						left_q   <= left_q - 1'b1;
						pend_q   <= 1'b1;
					end else begin
						pend_q <= 1'b0;
					end

					if (pend_q && match && op_q != OP_CANCEL) begin
						if (op_q == OP_SEARCH) begin
							res_from_q  <= qsel_q;
							res_id_q    <= sel_rdata[ENTRY_W-1:PAGES_W];
							res_pages_q <= sel_rdata[PAGES_W-1:0];
						end else begin
							res_status_q <= ST_DUPLICATE;
						end
						state_q <= S_FIN;
					end else if (pend_q && op_q == OP_CANCEL) begin
						if (match) begin
							hit_q <= 1'b1;
						end else begin
							wr_ptr_q <= wrap_next(wr_ptr_q);
							kept_q   <= kept_q + 1'b1;
						end
					end else if (walk_end) begin
						if (qsel_q) begin
							if (op_q == OP_CANCEL) begin
								p_tail_q <= wr_ptr_q;
								p_cnt_q  <= kept_q;
							end
							qsel_q   <= 1'b0;
							rd_ptr_q <= n_head_q;
							wr_ptr_q <= n_head_q;
							left_q   <= n_cnt_q;
							kept_q   <= '0;
						end else begin
							case (op_q)
								OP_SUBMIT: begin
									if (tgt_full) begin
										res_status_q <= ST_FULL;
									end else if (prio_q) begin
										p_tail_q <= wrap_next(p_tail_q);
										p_cnt_q  <= p_cnt_q + 1'b1;
									end else begin
										n_tail_q <= wrap_next(n_tail_q);
										n_cnt_q  <= n_cnt_q + 1'b1;
									end
								end
								OP_CANCEL: begin
									n_tail_q     <= wr_ptr_q;
									n_cnt_q      <= kept_q;
									res_status_q <= hit_q ? ST_OK : ST_NOT_FOUND;
								end
								default: begin
									res_status_q <= ST_NOT_FOUND;
								end
							endcase
							state_q <= S_FIN;
						end
					end
				end

				S_POP: begin
					res_from_q  <= qsel_q;
					res_id_q    <= sel_rdata[ENTRY_W-1:PAGES_W];
					res_pages_q <= sel_rdata[PAGES_W-1:0];
					state_q     <= S_FIN;
				end

				S_FIN: begin
					if (out_load) begin
						m_status_q <= res_status_q;
						m_from_q   <= res_from_q;
						m_id_q     <= res_id_q;
						m_pages_q  <= res_pages_q;
						state_q    <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {m_pages_q, m_id_q};
	assign m_tuser  = {m_from_q, m_status_q};

endmodule

`default_nettype wire
